### hdl/ray_obb_slab_test_macros.svh
// assertion macros for the ray box slab test
`ifndef RAY_OBB_SLAB_TEST_MACROS_SVH
`define RAY_OBB_SLAB_TEST_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ROST_ASSERT_NOW(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");
`define ROST_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ROST_ASSERT_NOW(lbl, cond)
`define ROST_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### hdl/rost_pkg.sv
// shared constants and types for the ray box slab test
`default_nettype none
package rost_pkg;
  localparam int AXIS_W     = 16;
  localparam int REG_W      = 48;
  localparam int CFG_IDX_W  = 3;
  localparam int T_W        = 32;
  localparam int Q_BITS     = 31;
  localparam int FRAC_BITS  = 16;
  localparam int HALF_SHIFT = 13;
  localparam int DIV_LAT    = Q_BITS + 3;
  localparam logic signed [T_W-1:0] T_MAX = {1'b0, {(T_W-1){1'b1}}};
  localparam logic signed [T_W-1:0] T_MIN = {1'b1, {(T_W-1){1'b0}}};
  localparam logic [REG_W-1:0] AXIS_U_RST = 48'h0000_0000_4000;
  localparam logic [REG_W-1:0] AXIS_V_RST = 48'h0000_4000_0000;
  localparam logic [REG_W-1:0] AXIS_W_RST = 48'h4000_0000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER = 3'd0,
    CFG_SIZE   = 3'd1,
    CFG_AXIS_U = 3'd2,
    CFG_AXIS_V = 3'd3,
    CFG_AXIS_W = 3'd4
  } cfg_reg_t;
endpackage
`default_nettype wire

### hdl/rost_div.sv
// pipelined restoring divider giving a saturated signed Q16.16 quotient
`default_nettype none
module rost_div #(
  parameter int NMW = 37,
  parameter int DMW = 34
) (
  input  wire logic                              clk,
  input  wire logic                              en,
  input  wire logic [NMW-1:0]                    num_mag,
  input  wire logic [DMW-1:0]                    den_mag,
  input  wire logic                              neg,
  output logic signed [rost_pkg::T_W-1:0]        t_out
);
  localparam int Q  = rost_pkg::Q_BITS;
  localparam int NW = NMW + rost_pkg::FRAC_BITS;
  localparam int CW = (DMW + Q > NW) ? DMW + Q : NW;

  logic [NMW-1:0] a_num_r;
  logic [DMW-1:0] a_den_r;
  logic           a_neg_r;

  logic [CW-1:0]  rem_r [0:Q];
  logic [Q-1:0]   q_r   [0:Q];
  logic [DMW-1:0] d_r   [0:Q];
  logic           neg_r [0:Q];
  logic           ovf_r [0:Q];

  logic [CW-1:0]  n_full;
  logic [CW-1:0]  d_top;

  assign n_full = CW'(a_num_r) << rost_pkg::FRAC_BITS;
  assign d_top  = CW'(a_den_r) << Q;

  always_ff @(posedge clk) begin
    if (en) begin
      a_num_r  <= num_mag;
      a_den_r  <= den_mag;
      a_neg_r  <= neg;
      // quotient of 2^31 or more saturates
      ovf_r[0] <= (n_full >= d_top);
      rem_r[0] <= n_full;
      q_r[0]   <= '0;
      d_r[0]   <= a_den_r;
      neg_r[0] <= a_neg_r;
    end
  end

  for (genvar k = 1; k <= Q; k++) begin : g_bit
    logic [CW-1:0] sub;
    logic          ge;
    assign sub = CW'(d_r[k-1]) << (Q - k);
    assign ge  = (rem_r[k-1] >= sub);
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? rem_r[k-1] - sub : rem_r[k-1];
        q_r[k]   <= {q_r[k-1][Q-2:0], ge};
        d_r[k]   <= d_r[k-1];
        neg_r[k] <= neg_r[k-1];
        ovf_r[k] <= ovf_r[k-1];
      end
    end
  end

  logic signed [rost_pkg::T_W-1:0] q_pos;
  assign q_pos = $signed({1'b0, q_r[Q]});

  always_ff @(posedge clk) begin
    if (en) begin
      if (ovf_r[Q]) begin
        t_out <= neg_r[Q] ? rost_pkg::T_MIN : rost_pkg::T_MAX;
      end else begin
        t_out <= neg_r[Q] ? -q_pos : q_pos;
      end
    end
  end
endmodule
`default_nettype wire

### hdl/ray_obb_slab_test.sv
// top level of the ray against oriented box slab test
//
//  port group | dir | payload (lowest bits first)
//  in_*       | in  | origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
//  out_*      | out | hit
//  cfg_*      | in  | box_center, box_size, axis_u, axis_v, axis_w by index
//
// one item enters per cycle unless the result stalls; there are four stages
// of products and sums, 34 in each of the six slab dividers (one quotient bit
// per bit stage), one ordering stage and one per box axis. reset clears the
// valid bits, zeroes centre and size, sets the default axes. a stalled result
// holds the whole pipeline and the input; bubbles are not squeezed out.
`default_nettype none
`include "ray_obb_slab_test_macros.svh"
module ray_obb_slab_test #(
  parameter int COORD_WIDTH = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, zero fill
  input  wire logic [((6*COORD_WIDTH+7)/8)*8-1:0]  in_tdata,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // hit, zero fill
  output logic [7:0]                               out_tdata,
  input  wire logic                                cfg_wr_en,
  input  wire logic [rost_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [rost_pkg::REG_W-1:0]          cfg_wdata
);
  localparam int W     = COORD_WIDTH;
  localparam int AW    = rost_pkg::AXIS_W;
  localparam int RW    = rost_pkg::REG_W;
  localparam int TW    = rost_pkg::T_W;
  localparam int LANEW = (3 * W > RW) ? 3 * W : RW;
  localparam int DLW   = W + 1;
  localparam int PW    = DLW + AW;
  localparam int PFW   = W + AW;
  localparam int EW    = PW + 2;
  localparam int FW    = PFW + 2;
  localparam int HW    = W + rost_pkg::HALF_SHIFT;
  localparam int NSW   = EW + 1;
  localparam int DL    = rost_pkg::DIV_LAT;
  localparam int S_ORD = 4 + DL + 1;
  localparam int NST   = S_ORD + 3;

  typedef struct packed {
    logic [2:0] fz;
    logic [2:0] pm;
  } side_t;

  // configuration registers
  logic [RW-1:0] center_r, size_r;
  logic [RW-1:0] axis_r [0:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_r  <= '0;
      size_r    <= '0;
      axis_r[0] <= rost_pkg::AXIS_U_RST;
      axis_r[1] <= rost_pkg::AXIS_V_RST;
      axis_r[2] <= rost_pkg::AXIS_W_RST;
    end else if (cfg_wr_en) begin
      unique case (rost_pkg::cfg_reg_t'(cfg_index))
        rost_pkg::CFG_CENTER: center_r  <= cfg_wdata;
        rost_pkg::CFG_SIZE:   size_r    <= cfg_wdata;
        rost_pkg::CFG_AXIS_U: axis_r[0] <= cfg_wdata;
        rost_pkg::CFG_AXIS_V: axis_r[1] <= cfg_wdata;
        rost_pkg::CFG_AXIS_W: axis_r[2] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic [LANEW-1:0] center_ext, size_ext;
  assign center_ext = LANEW'(center_r);
  assign size_ext   = LANEW'(size_r);

  // pipeline control
  logic           en;
  logic [1:NST]   vld_r;

  assign en        = !vld_r[NST] || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {in_tvalid, vld_r[1:NST-1]};
    end
  end

  // stage 1: centre minus origin
  logic signed [DLW-1:0] dlt_r [0:2];
  logic signed [W-1:0]   dir_r [0:2];

  for (genvar k = 0; k < 3; k++) begin : g_s1
    logic signed [W-1:0] c_k, o_k;
    assign c_k = $signed(center_ext[k*W +: W]);
    assign o_k = $signed(in_tdata[k*W +: W]);
    always_ff @(posedge clk) begin
      if (en) begin
        dlt_r[k] <= DLW'(c_k) - DLW'(o_k);
        dir_r[k] <= $signed(in_tdata[(k+3)*W +: W]);
      end
    end
  end

  // stage 2: products with the axis components
  logic signed [PW-1:0]  pe_r [0:2][0:2];
  logic signed [PFW-1:0] pf_r [0:2][0:2];

  for (genvar a = 0; a < 3; a++) begin : g_s2a
    for (genvar k = 0; k < 3; k++) begin : g_s2k
      logic signed [AW-1:0] ax;
      assign ax = $signed(axis_r[a][k*AW +: AW]);
      always_ff @(posedge clk) begin
        if (en) begin
          pe_r[a][k] <= PW'(dlt_r[k]) * PW'(ax);
          pf_r[a][k] <= PFW'(dir_r[k]) * PFW'(ax);
        end
      end
    end
  end

  // stage 3: dot products
  logic signed [EW-1:0] e_r [0:2];
  logic signed [FW-1:0] f_r [0:2];

  for (genvar a = 0; a < 3; a++) begin : g_s3
    always_ff @(posedge clk) begin
      if (en) begin
        e_r[a] <= EW'(pe_r[a][0]) + EW'(pe_r[a][1]) + EW'(pe_r[a][2]);
        f_r[a] <= FW'(pf_r[a][0]) + FW'(pf_r[a][1]) + FW'(pf_r[a][2]);
      end
    end
  end

  // stage 4: slab numerators and the parallel case
  logic signed [NSW-1:0] n_r  [0:2][0:1];
  logic signed [FW-1:0]  f4_r [0:2];
  side_t                 side4_r;

  for (genvar a = 0; a < 3; a++) begin : g_s4
    logic signed [NSW-1:0] half_s, e_s;
    assign half_s = $signed(NSW'({size_ext[a*W +: W], {rost_pkg::HALF_SHIFT{1'b0}}}));
    assign e_s    = NSW'(e_r[a]);
    always_ff @(posedge clk) begin
      if (en) begin
        n_r[a][0]      <= e_s + half_s;
        n_r[a][1]      <= e_s - half_s;
        f4_r[a]        <= f_r[a];
        side4_r.fz[a]  <= (f_r[a] == '0);
        side4_r.pm[a]  <= (e_s < -half_s) || (e_s > half_s);
      end
    end
  end

  // slab crossings through the dividers
  logic signed [TW-1:0] t_q [0:2][0:1];

  for (genvar a = 0; a < 3; a++) begin : g_div_a
    logic [FW-1:0] den_mag;
    assign den_mag = f4_r[a][FW-1] ? FW'(-f4_r[a]) : FW'(f4_r[a]);
    for (genvar j = 0; j < 2; j++) begin : g_div_j
      logic [NSW-1:0] num_mag;
      assign num_mag = n_r[a][j][NSW-1] ? NSW'(-n_r[a][j]) : NSW'(n_r[a][j]);
      rost_div #(
        .NMW (NSW),
        .DMW (FW)
      ) u_div (
        .clk     (clk),
        .en      (en),
        .num_mag (num_mag),
        .den_mag (den_mag),
        .neg     (n_r[a][j][NSW-1] ^ f4_r[a][FW-1]),
        .t_out   (t_q[a][j])
      );
    end
  end

  // side flags keep step with the dividers
  side_t side_r [0:DL-1];

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side4_r;
    end
  end

  for (genvar i = 1; i < DL; i++) begin : g_side
    always_ff @(posedge clk) begin
      if (en) begin
        side_r[i] <= side_r[i-1];
      end
    end
  end

  // ordering stage: entry and exit per axis
  logic signed [TW-1:0] lo_r [0:2];
  logic signed [TW-1:0] hi_r [0:2];
  side_t                sord_r;

  for (genvar a = 0; a < 3; a++) begin : g_ord
    always_ff @(posedge clk) begin
      if (en) begin
        if (t_q[a][0] > t_q[a][1]) begin
          lo_r[a] <= t_q[a][1];
          hi_r[a] <= t_q[a][0];
        end else begin
          lo_r[a] <= t_q[a][0];
          hi_r[a] <= t_q[a][1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sord_r <= side_r[DL-1];
    end
  end

  // one stage per axis narrows the interval
  logic signed [TW-1:0] tmn_r [0:2];
  logic signed [TW-1:0] tmx_r [0:2];
  logic                 rj_r  [0:2];
  logic signed [TW-1:0] lo_k_r [0:2][0:2];
  logic signed [TW-1:0] hi_k_r [0:2][0:2];
  side_t                sd_k_r [0:2];

  for (genvar k = 0; k < 3; k++) begin : g_ax
    logic signed [TW-1:0] tmn_i, tmx_i, lo_i, hi_i, tmn_n, tmx_n;
    logic                 rj_i, rj_n;
    side_t                sd_i;
    logic signed [TW-1:0] lo_a [0:2];
    logic signed [TW-1:0] hi_a [0:2];

    if (k == 0) begin : g_first
      assign tmn_i = '0;
      assign tmx_i = rost_pkg::T_MAX;
      assign rj_i  = 1'b0;
      assign sd_i  = sord_r;
      for (genvar a = 0; a < 3; a++) begin : g_cp
        assign lo_a[a] = lo_r[a];
        assign hi_a[a] = hi_r[a];
      end
    end else begin : g_rest
      assign tmn_i = tmn_r[k-1];
      assign tmx_i = tmx_r[k-1];
      assign rj_i  = rj_r[k-1];
      assign sd_i  = sd_k_r[k-1];
      for (genvar a = 0; a < 3; a++) begin : g_cp
        assign lo_a[a] = lo_k_r[k-1][a];
        assign hi_a[a] = hi_k_r[k-1][a];
      end
    end

    assign lo_i = lo_a[k];
    assign hi_i = hi_a[k];

    always_comb begin
      if (sd_i.fz[k]) begin
        tmn_n = tmn_i;
        tmx_n = tmx_i;
        rj_n  = sd_i.pm[k];
      end else begin
        tmn_n = (lo_i > tmn_i) ? lo_i : tmn_i;
        tmx_n = (hi_i < tmx_i) ? hi_i : tmx_i;
        rj_n  = (tmn_n > tmx_n) || tmx_n[TW-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        tmn_r[k]  <= tmn_n;
        tmx_r[k]  <= tmx_n;
        rj_r[k]   <= rj_i || rj_n;
        sd_k_r[k] <= sd_i;
        for (int a = 0; a < 3; a++) begin
          lo_k_r[k][a] <= lo_a[a];
          hi_k_r[k][a] <= hi_a[a];
        end
      end
    end
  end

  assign out_tvalid = vld_r[NST];
  assign out_tdata  = {7'b0, !rj_r[2]};

  `ROST_ASSERT_NOW(a_stall_blocks_input, !(out_tvalid && !out_tready && in_tready))
  `ROST_ASSERT_NEXT(a_item_enters, in_tvalid && in_tready, vld_r[1])
  `ROST_ASSERT_NEXT(a_stall_holds_valids, !en, vld_r == $past(vld_r))
endmodule
`default_nettype wire
